FILE: rtl/adsr_pkg.sv
// shared types, codes and constants of the adsr envelope generator
`default_nettype none

package adsr_pkg;

   // level format
   localparam int LEVEL_BITS = 16;
   localparam int FACTOR_BITS = 16;
   localparam int PROD_BITS = LEVEL_BITS + FACTOR_BITS;

   typedef logic [LEVEL_BITS-1:0] level_type;
   typedef logic [FACTOR_BITS-1:0] factor_type;
   typedef logic [PROD_BITS-1:0] product_type;

   // idle threshold, round(0.001 * 2^LEVEL_BITS)
   localparam level_type NEAR_ZERO = LEVEL_BITS'(((64'd1 << LEVEL_BITS) + 64'd500) / 64'd1000);

   // envelope stages
   typedef logic [2:0] stage_type;
   localparam stage_type STAGE_IDLE = 3'd0;
   localparam stage_type STAGE_ATTACK = 3'd1;
   localparam stage_type STAGE_DECAY = 3'd2;
   localparam stage_type STAGE_SUSTAIN = 3'd3;
   localparam stage_type STAGE_RELEASE = 3'd4;

   // request actions
   typedef logic [1:0] action_type;
   localparam action_type ACT_TICK = 2'd0;
   localparam action_type ACT_START = 2'd1;
   localparam action_type ACT_RELEASE = 2'd2;

   // register indexes
   localparam int CSR_INDEX_BITS = 3;
   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;
   localparam csr_index_type CSR_ENABLE = 3'd0;
   localparam csr_index_type CSR_ATTACK_STEP = 3'd1;
   localparam csr_index_type CSR_DECAY_FACTOR = 3'd2;
   localparam csr_index_type CSR_SUSTAIN_LEVEL = 3'd3;
   localparam csr_index_type CSR_RELEASE_FACTOR = 3'd4;

   // register reset values
   localparam factor_type RESET_ATTACK_STEP = 16'd655;
   localparam factor_type RESET_DECAY_FACTOR = 16'd64880;
   localparam factor_type RESET_SUSTAIN_LEVEL = 16'd45875;
   localparam factor_type RESET_RELEASE_FACTOR = 16'd64880;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic mul_first;
      logic prep;
      logic mul_second;
      logic commit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic decay_path;
   } status_type;

endpackage

`default_nettype wire

FILE: rtl/adsr_ctrl.sv
// controller state machine: sequences one beat through the shared multiplier
`default_nettype none

module adsr_ctrl
   import adsr_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  wire        rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL1 = 3'd1;
   localparam logic [2:0] S_PREP = 3'd2;
   localparam logic [2:0] S_MUL2 = 3'd3;
   localparam logic [2:0] S_COMMIT = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;

   // output register can take a result this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // command decode and next state
   always_comb begin
      cmd = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_MUL1;
            end
         end
         S_MUL1: begin
            cmd.mul_first = 1'b1;
            state_in = status.decay_path ? S_PREP : S_COMMIT;
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul_second = 1'b1;
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/adsr_datapath.sv
// datapath: registers, envelope state, shared multiplier and result register
`default_nettype none

module adsr_datapath
   import adsr_pkg::*;
(
   input  wire           clock,
   input  wire           reset,
   input  cmd_type       cmd,
   output status_type    status,
   input  wire           csr_valid,
   input  csr_index_type csr_index,
   input  wire [15:0]    csr_wdata,
   input  action_type    req_action,
   input  level_type     req_note_level,
   output level_type     rsp_gain_out,
   output stage_type     rsp_stage_out,
   output logic          rsp_voice_active
);

   // configuration registers
   logic       enable_ff;
   factor_type attack_step_ff;
   factor_type decay_factor_ff;
   factor_type sustain_level_ff;
   factor_type release_factor_ff;

   // envelope state
   stage_type stage_ff;
   stage_type stage_in;
   level_type gain_ff;
   level_type gain_in;
   level_type held_ff;
   level_type held_in;
   logic      pend_ff;
   logic      pend_in;

   // latched beat and working registers
   action_type act_ff;
   level_type  level_ff;
   level_type  prod_hi_ff;
   level_type  goal_ff;
   level_type  diff_ff;
   logic       below_ff;

   // result register
   level_type rsp_gain_ff;
   stage_type rsp_stage_ff;

   stage_type   eff_stage;
   logic        tick_work;
   level_type   mul_a;
   factor_type  mul_b;
   product_type product;
   logic [LEVEL_BITS:0] attack_sum;

   assign rsp_gain_out = rsp_gain_ff;
   assign rsp_stage_out = rsp_stage_ff;
   assign rsp_voice_active = (rsp_stage_ff != STAGE_IDLE);

   // a pending release takes over the stage on the next enabled tick
   assign eff_stage = pend_ff ? STAGE_RELEASE : stage_ff;
   assign tick_work = (act_ff == ACT_TICK) && (stage_ff != STAGE_IDLE) && enable_ff;
   assign status.decay_path = tick_work && (eff_stage == STAGE_DECAY);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
         attack_step_ff <= RESET_ATTACK_STEP;
         decay_factor_ff <= RESET_DECAY_FACTOR;
         sustain_level_ff <= RESET_SUSTAIN_LEVEL;
         release_factor_ff <= RESET_RELEASE_FACTOR;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ENABLE: enable_ff <= csr_wdata[0];
            CSR_ATTACK_STEP: attack_step_ff <= csr_wdata;
            CSR_DECAY_FACTOR: decay_factor_ff <= csr_wdata;
            CSR_SUSTAIN_LEVEL: sustain_level_ff <= csr_wdata;
            CSR_RELEASE_FACTOR: release_factor_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = gain_ff;
      mul_b = release_factor_ff;
      if (cmd.mul_second) begin
         mul_a = diff_ff;
         mul_b = decay_factor_ff;
      end else begin
         case (eff_stage)
            STAGE_ATTACK: begin
               mul_a = held_ff;
               mul_b = attack_step_ff;
            end
            STAGE_DECAY: begin
               mul_a = held_ff;
               mul_b = sustain_level_ff;
            end
            default: begin
               mul_a = gain_ff;
               mul_b = release_factor_ff;
            end
         endcase
      end
   end

   assign product = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);

   // latched beat, product and decay preparation
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff <= req_action;
         level_ff <= req_note_level;
      end
      if (cmd.mul_first || cmd.mul_second) begin
         prod_hi_ff <= product[PROD_BITS-1:FACTOR_BITS];
      end
      if (cmd.prep) begin
         goal_ff <= prod_hi_ff;
         below_ff <= (gain_ff <= prod_hi_ff);
         diff_ff <= gain_ff - prod_hi_ff;
      end
   end

   assign attack_sum = {1'b0, gain_ff} + {1'b0, prod_hi_ff};

   // next envelope state at commit
   always_comb begin
      stage_in = stage_ff;
      gain_in = gain_ff;
      held_in = held_ff;
      pend_in = pend_ff;
      case (act_ff)
         ACT_START: begin
            held_in = level_ff;
            gain_in = '0;
            stage_in = STAGE_ATTACK;
            pend_in = 1'b0;
         end
         ACT_RELEASE: begin
            if (stage_ff != STAGE_IDLE) begin
               pend_in = 1'b1;
            end
         end
         ACT_TICK: begin
            if (stage_ff != STAGE_IDLE && !enable_ff) begin
               gain_in = held_ff;
            end else if (tick_work) begin
               stage_in = eff_stage;
               case (eff_stage)
                  STAGE_ATTACK: begin
                     if (attack_sum >= {1'b0, held_ff}) begin
                        gain_in = held_ff;
                        stage_in = STAGE_DECAY;
                     end else begin
                        gain_in = attack_sum[LEVEL_BITS-1:0];
                     end
                  end
                  STAGE_DECAY: begin
                     if (below_ff || prod_hi_ff < NEAR_ZERO) begin
                        gain_in = goal_ff;
                        stage_in = STAGE_SUSTAIN;
                     end else begin
                        gain_in = goal_ff + prod_hi_ff;
                     end
                  end
                  STAGE_RELEASE: begin
                     if (prod_hi_ff < NEAR_ZERO) begin
                        gain_in = '0;
                        stage_in = STAGE_IDLE;
                        pend_in = 1'b0;
                     end else begin
                        gain_in = prod_hi_ff;
                     end
                  end
                  default: ;
               endcase
            end
         end
         default: ;
      endcase
   end

   // envelope state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= STAGE_IDLE;
         gain_ff <= '0;
         held_ff <= '0;
         pend_ff <= 1'b0;
      end else if (cmd.commit) begin
         stage_ff <= stage_in;
         gain_ff <= gain_in;
         held_ff <= held_in;
         pend_ff <= pend_in;
      end
   end

   // result register, held while the result beat waits
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_gain_ff <= gain_in;
         rsp_stage_ff <= stage_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/adsr_envelope_generator_unit.sv
// top level of the adsr envelope generator: controller plus datapath
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_action, req_note_level
//   rsp      out        rsp_valid/rsp_stall  rsp_gain_out, rsp_stage_out, rsp_voice_active
//   csr      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// a beat steps through mul1 and commit (start, release, attack or release tick) or mul1,
// prep, mul2 and commit (decay tick); the single 16x16 multiplier is used once, twice in decay.
// a new beat is taken while the previous result still waits in the output register.
// a result that is stalled holds the block in its commit step until taken.
// synchronous reset restores the register defaults and an idle voice.
`default_nettype none

module adsr_envelope_generator_unit
   import adsr_pkg::*;
(
   input  wire           clock,
   input  wire           reset,
   input  wire           req_valid,
   output logic          req_stall,
   input  action_type    req_action,
   input  level_type     req_note_level,
   output logic          rsp_valid,
   input  wire           rsp_stall,
   output level_type     rsp_gain_out,
   output stage_type     rsp_stage_out,
   output logic          rsp_voice_active,
   input  wire           csr_valid,
   output logic          csr_ready,
   input  csr_index_type csr_index,
   input  wire [15:0]    csr_wdata
);

   cmd_type    cmd;
   status_type status;

   // register writes are always taken
   assign csr_ready = 1'b1;

   adsr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   adsr_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_valid        (csr_valid),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_action       (req_action),
      .req_note_level   (req_note_level),
      .rsp_gain_out     (rsp_gain_out),
      .rsp_stage_out    (rsp_stage_out),
      .rsp_voice_active (rsp_voice_active)
   );

endmodule

`default_nettype wire

FILE: bench/tb_adsr_envelope_generator_unit.sv
// testbench of the adsr envelope generator: envelope scoreboard, stimulus tasks and checks

// expected envelope beats, worked out from a local copy of the voice and registers
class envelope_scoreboard;
   localparam int IDLE_THRESHOLD = ((1 << 16) + 500) / 1000;

   typedef struct packed {
      adsr_pkg::level_type gain;
      adsr_pkg::stage_type stage;
      logic                active;
   } envelope_beat_type;

   // register copies
   logic        enable;
   logic [15:0] attack_step;
   logic [15:0] decay_factor;
   logic [15:0] sustain_level;
   logic [15:0] release_factor;

   // voice copy
   adsr_pkg::stage_type stage;
   logic [15:0]         gain;
   logic [15:0]         held_level;
   logic                release_pending;

   envelope_beat_type expected_envelopes[$];
   int                error_count;

   function new();
      enable = 1'b1;
      attack_step = 16'd655;
      decay_factor = 16'd64880;
      sustain_level = 16'd45875;
      release_factor = 16'd64880;
      stage = adsr_pkg::STAGE_IDLE;
      gain = '0;
      held_level = '0;
      release_pending = 1'b0;
      error_count = 0;
   endfunction

   task report(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      error_count++;
   endtask

   // q0.16 product, truncated
   function logic [15:0] scale_q16(input logic [15:0] value, input logic [15:0] factor);
      logic [31:0] product;
      product = {16'd0, value} * {16'd0, factor};
      return product[31:16];
   endfunction

   // one envelope tick
   function void advance_envelope();
      logic [16:0] attack_sum;
      logic [15:0] goal;
      if (stage == adsr_pkg::STAGE_IDLE) return;
      if (!enable) begin
         gain = held_level;
         return;
      end
      if (release_pending) stage = adsr_pkg::STAGE_RELEASE;
      case (stage)
         adsr_pkg::STAGE_ATTACK: begin
            attack_sum = {1'b0, gain} + {1'b0, scale_q16(held_level, attack_step)};
            if (attack_sum >= {1'b0, held_level}) begin
               gain = held_level;
               stage = adsr_pkg::STAGE_DECAY;
            end else begin
               gain = attack_sum[15:0];
            end
         end
         adsr_pkg::STAGE_DECAY: begin
            goal = scale_q16(held_level, sustain_level);
            if (gain <= goal) begin
               gain = goal;
               stage = adsr_pkg::STAGE_SUSTAIN;
            end else begin
               gain = goal + scale_q16(gain - goal, decay_factor);
               if (32'(gain - goal) < IDLE_THRESHOLD) begin
                  gain = goal;
                  stage = adsr_pkg::STAGE_SUSTAIN;
               end
            end
         end
         adsr_pkg::STAGE_RELEASE: begin
            gain = scale_q16(gain, release_factor);
            if (32'(gain) < IDLE_THRESHOLD) begin
               gain = '0;
               stage = adsr_pkg::STAGE_IDLE;
               release_pending = 1'b0;
            end
         end
         default: ;
      endcase
   endfunction

   // accepted request beat: update the voice and queue the expected result
   function void note_request(input adsr_pkg::action_type action,
                              input adsr_pkg::level_type level);
      envelope_beat_type beat;
      case (action)
         adsr_pkg::ACT_TICK: advance_envelope();
         adsr_pkg::ACT_START: begin
            held_level = level;
            gain = '0;
            stage = adsr_pkg::STAGE_ATTACK;
            release_pending = 1'b0;
         end
         adsr_pkg::ACT_RELEASE: begin
            if (stage != adsr_pkg::STAGE_IDLE) release_pending = 1'b1;
         end
         default: ;
      endcase
      beat.gain = gain;
      beat.stage = stage;
      beat.active = (stage != adsr_pkg::STAGE_IDLE);
      expected_envelopes.insert(expected_envelopes.size(), beat);
   endfunction

   // accepted result beat against the oldest expectation
   task check_response(input adsr_pkg::level_type gain_seen,
                       input adsr_pkg::stage_type stage_seen,
                       input logic active_seen);
      envelope_beat_type want;
      if (expected_envelopes.size() == 0) begin
         report($sformatf("unexpected result gain %0d stage %0d", gain_seen, stage_seen));
      end else begin
         want = expected_envelopes[0];
         expected_envelopes.delete(0);
         if (gain_seen !== want.gain)
            report($sformatf("gain %0d, expected %0d", gain_seen, want.gain));
         if (stage_seen !== want.stage)
            report($sformatf("stage %0d, expected %0d", stage_seen, want.stage));
         if (active_seen !== want.active)
            report($sformatf("voice_active %0b, expected %0b", active_seen, want.active));
      end
   endtask

   function void write_register(input adsr_pkg::csr_index_type index, input logic [15:0] data);
      case (index)
         adsr_pkg::CSR_ENABLE: enable = data[0];
         adsr_pkg::CSR_ATTACK_STEP: attack_step = data;
         adsr_pkg::CSR_DECAY_FACTOR: decay_factor = data;
         adsr_pkg::CSR_SUSTAIN_LEVEL: sustain_level = data;
         adsr_pkg::CSR_RELEASE_FACTOR: release_factor = data;
         default: ;
      endcase
   endfunction
endclass

module tb_adsr_envelope_generator_unit;
   import adsr_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES = 10;
   localparam int RANDOM_PHASES = 12;
   // phases overrun their share by part of a note, so the total lands near 1050
   localparam int RANDOM_ITEMS = 840;
   localparam csr_index_type CSR_UNUSED = CSR_RELEASE_FACTOR + 3'd1;
   localparam action_type ACT_UNUSED = 2'd3;

   typedef enum {FLOW_FREE, FLOW_SENDER_IDLE, FLOW_RECEIVER_STALL, FLOW_BOTH} flow_mode_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   action_type    req_action = ACT_TICK;
   level_type     req_note_level = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   level_type     rsp_gain_out;
   stage_type     rsp_stage_out;
   logic          rsp_voice_active;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = CSR_ENABLE;
   logic [15:0]   csr_wdata = '0;

   int idle_pct = 0;
   int stall_pct = 0;
   int items_sent = 0;

   envelope_scoreboard sb = new();

   adsr_envelope_generator_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_action(req_action),
      .req_note_level(req_note_level),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_gain_out(rsp_gain_out),
      .rsp_stage_out(rsp_stage_out),
      .rsp_voice_active(rsp_voice_active),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);
   end

   // beat monitor: requests, results and register writes
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_request(req_action, req_note_level);
         if (rsp_valid && !rsp_stall)
            sb.check_response(rsp_gain_out, rsp_stage_out, rsp_voice_active);
         if (csr_valid && csr_ready) sb.write_register(csr_index, csr_wdata);
      end
   end

   // watchdog on cycles without any accepted beat
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("adsr_envelope_generator_unit: mismatch");
      $finish;
   end

   function automatic void apply_flow(input flow_mode_type mode);
      case (mode)
         FLOW_SENDER_IDLE: begin idle_pct = 69; stall_pct = 0; end
         FLOW_RECEIVER_STALL: begin idle_pct = 0; stall_pct = 69; end
         FLOW_BOTH: begin idle_pct = 18; stall_pct = 18; end
         default: begin idle_pct = 0; stall_pct = 0; end
      endcase
   endfunction

   function automatic logic [15:0] pick_level();
      case ($urandom_range(7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(255));
         default: return 16'($urandom_range(65535));
      endcase
   endfunction

   function automatic logic [15:0] pick_factor();
      case ($urandom_range(5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(65535));
         default: return 16'($urandom_range(50000, 8000));
      endcase
   endfunction

   function automatic logic [15:0] pick_step();
      case ($urandom_range(5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(65535));
         default: return 16'($urandom_range(40000, 3000));
      endcase
   endfunction

   // one request beat, after a random idle gap
   task automatic send_request(input action_type action, input level_type level);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= action;
      req_note_level <= level;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_tick();
      send_request(ACT_TICK, 16'($urandom_range(65535)));
   endtask

   // stop sending and let every expected result come back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (sb.expected_envelopes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // register write beat; the caller lowers csr_valid after the last one
   task automatic write_csr(input csr_index_type index, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic program_envelope(input logic enable, input logic [15:0] attack,
                                   input logic [15:0] decay, input logic [15:0] sustain,
                                   input logic [15:0] release_mul);
      wait_for_drain();
      write_csr(CSR_ENABLE, {15'($urandom_range(32767)), enable});
      write_csr(CSR_ATTACK_STEP, attack);
      write_csr(CSR_DECAY_FACTOR, decay);
      write_csr(CSR_SUSTAIN_LEVEL, sustain);
      write_csr(CSR_RELEASE_FACTOR, release_mul);
      csr_valid <= 1'b0;
   endtask

   // mostly whole notes with random lengths, some stray beats
   task automatic play_random_note();
      int hold_ticks;
      int tail_ticks;
      hold_ticks = $urandom_range(24);
      tail_ticks = $urandom_range(30);
      if ($urandom_range(99) < 15) begin
         send_request(action_type'($urandom_range(3)), 16'($urandom_range(65535)));
      end else begin
         send_request(ACT_START, pick_level());
         repeat (hold_ticks) send_tick();
         if ($urandom_range(99) < 75) begin
            send_request(ACT_RELEASE, 16'($urandom_range(65535)));
            repeat (tail_ticks) send_tick();
         end
      end
   endtask

   initial begin
      int phase;
      int phase_end;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      apply_flow(FLOW_FREE);

      // idle voice: tick, release and the unused action change nothing
      send_tick();
      send_request(ACT_RELEASE, 16'hFFFF);
      send_request(ACT_UNUSED, 16'h0000);

      // silent note with reset registers
      send_request(ACT_START, 16'h0000);
      send_tick();
      send_tick();
      send_request(ACT_RELEASE, 16'h0000);
      send_tick();

      // full-scale note, an unused action mid-note, then a release
      send_request(ACT_START, 16'hFFFF);
      send_tick();
      send_tick();
      send_request(ACT_UNUSED, 16'hFFFF);
      send_request(ACT_RELEASE, 16'h5555);
      send_tick();
      send_tick();

      // a write to an unused register index is dropped
      wait_for_drain();
      write_csr(CSR_UNUSED, 16'($urandom_range(65535)));
      csr_valid <= 1'b0;

      // saturating attack, instant decay, full sustain, instant release
      program_envelope(1'b1, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
      send_request(ACT_START, 16'hFFFF);
      send_tick();
      send_tick();
      send_tick();
      send_request(ACT_RELEASE, 16'hAAAA);
      send_tick();

      // disabled envelope follows the note level, release waits for enable
      program_envelope(1'b0, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
      send_request(ACT_START, 16'd40000);
      send_tick();
      send_request(ACT_RELEASE, 16'd0);
      send_tick();
      program_envelope(1'b1, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
      send_tick();

      // random phases, each with its own register setting and flow mode
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == 0)
            program_envelope(1'b1, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
         else
            program_envelope($urandom_range(9) != 0, pick_step(), pick_factor(),
                             pick_factor(), pick_factor());
         apply_flow(flow_mode_type'(phase % 4));
         phase_end = items_sent + RANDOM_ITEMS / RANDOM_PHASES;
         while (items_sent < phase_end) play_random_note();
      end

      wait_for_drain();
      if (sb.expected_envelopes.size() != 0)
         sb.report($sformatf("%0d results never arrived", sb.expected_envelopes.size()));
      if (sb.error_count == 0)
         $display("adsr_envelope_generator_unit: match");
      else
         $display("adsr_envelope_generator_unit: mismatch");
      $finish;
   end
endmodule

FILE: adsr_envelope_generator_unit.f
rtl/adsr_pkg.sv
rtl/adsr_ctrl.sv
rtl/adsr_datapath.sv
rtl/adsr_envelope_generator_unit.sv
bench/tb_adsr_envelope_generator_unit.sv
